// ----- sv/dws_pkg.sv -----
// ----------------------------------------------------------------------------
// dws_pkg
// Shared constants and types for the double-ended queue with search.
// ----------------------------------------------------------------------------
package dws_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 5;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int POSX_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_SEARCH     = 3'd4
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CM_HOLD = 2'd0,
        CM_LOAD = 2'd1,
        CM_SHR  = 2'd2,
        CM_SHL  = 2'd3
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode mode;
        logic       tok_run;
    } t_cell_ctrl;

endpackage

// ----- sv/dws_cell.sv -----
// ----------------------------------------------------------------------------
// dws_cell
// One storage cell of the queue: holds one entry, shifts toward either
// neighbor, and compares its entry against the search key when the search
// token passes through it.
// ----------------------------------------------------------------------------
module dws_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dws_pkg::t_cell_ctrl                i_ctrl,
    input  logic signed [dws_pkg::DATA_W-1:0]  i_load_value,
    input  logic signed [dws_pkg::DATA_W-1:0]  i_from_left,
    input  logic signed [dws_pkg::DATA_W-1:0]  i_from_right,
    input  logic                               i_tok,
    input  logic signed [dws_pkg::DATA_W-1:0]  i_key,
    output logic signed [dws_pkg::DATA_W-1:0]  o_data,
    output logic                               o_tok,
    output logic                               o_hit
);
    import dws_pkg::*;

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic                     r_tok;

    always_comb begin
        case (i_ctrl.mode)
            CM_LOAD: n_data = i_load_value;
            CM_SHR:  n_data = i_from_left;
            CM_SHL:  n_data = i_from_right;
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_ctrl.tok_run & i_tok;
        end
    end

    assign o_data = r_data;
    assign o_tok  = r_tok;
    assign o_hit  = r_tok && (r_data == i_key);

endmodule

// ----- sv/deque_with_search.sv -----
// ----------------------------------------------------------------------------
// deque_with_search
// Bounded double-ended queue of signed 32-bit values with linear search.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  (i_valid / o_ready): i_operation, i_value.
//   Output channel (o_valid / i_ready): o_status, o_popped_value, o_position.
//   Every input transaction gives exactly one output transaction.
//   Entries sit in a row of cells, front at cell 0. A front push or pop
//   moves the whole row one cell; a rear push loads one cell and a rear pop
//   only reads one. Results show in the cycle after the input transaction;
//   while results are taken, such operations can follow in every cycle.
//   A search sends a token down the row, one cell per cycle, each cell
//   comparing its entry with the key. It stops at the first match or, when
//   there is none, at the rear entry. No input is taken during a search.
//   Reset clears the state, the occupancy and the output valid flag; entry
//   contents are not reset. While the receiver stalls, the result is held
//   and o_ready stays low until the result is taken.
// ----------------------------------------------------------------------------
module deque_with_search (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [dws_pkg::OP_W-1:0]            i_operation,
    input  logic signed [dws_pkg::DATA_W-1:0]   i_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [dws_pkg::STAT_W-1:0]          o_status,
    output logic signed [dws_pkg::DATA_W-1:0]   o_popped_value,
    output logic [dws_pkg::POS_W-1:0]           o_position
);
    import dws_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_SEARCH = 2'b10
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [IDX_W-1:0]         r_idx;
    logic [IDX_W-1:0]         n_idx;
    logic signed [DATA_W-1:0] r_key;

    logic                     r_out_valid;
    logic                     n_out_valid;
    t_status                  r_out_status;
    t_status                  n_out_status;
    logic signed [DATA_W-1:0] r_out_popped;
    logic signed [DATA_W-1:0] n_out_popped;
    logic [POS_W-1:0]         r_out_pos;
    logic [POS_W-1:0]         n_out_pos;

    t_cell_ctrl               w_ctrl [DEPTH];
    logic signed [DATA_W-1:0] w_data [DEPTH];
    logic                     w_tok  [DEPTH];
    logic [DEPTH-1:0]         w_hit;

    logic                     w_accept;
    logic                     w_empty;
    logic                     w_full;
    logic                     w_start;
    logic                     w_any_hit;
    logic                     w_last;
    logic                     w_done;
    logic [IDX_W-1:0]         w_rear_idx;
    logic [POSX_W-1:0]        w_pos_x;
    t_op                      w_op;

    assign w_op       = t_op'(i_operation);
    assign o_ready    = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign w_accept   = i_valid && o_ready;
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_start    = w_accept && (w_op == OP_SEARCH) && !w_empty;
    assign w_any_hit  = |w_hit;
    assign w_last     = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign w_done     = (r_state == S_SEARCH) && (w_any_hit || w_last);
    assign w_rear_idx = IDX_W'(r_count - CNT_W'(1));
    assign w_pos_x    = POSX_W'(r_idx) + POSX_W'(1);

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_ctrl[i].mode    = CM_HOLD;
            w_ctrl[i].tok_run = w_start || ((r_state == S_SEARCH) && !w_done);
            if (w_accept) begin
                case (w_op)
                    OP_PUSH_FRONT: if (!w_full) w_ctrl[i].mode = CM_SHR;
                    OP_PUSH_REAR: begin
                        if (!w_full && (CNT_W'(i) == r_count)) w_ctrl[i].mode = CM_LOAD;
                    end
                    OP_POP_FRONT:  if (!w_empty) w_ctrl[i].mode = CM_SHL;
                    default:       w_ctrl[i].mode = CM_HOLD;
                endcase
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;
        logic                     w_tok_in;

        if (g == 0) begin : g_head
            assign w_left   = i_value;
            assign w_tok_in = w_start;
        end else begin : g_body
            assign w_left   = w_data[g-1];
            assign w_tok_in = w_tok[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid
            assign w_right = w_data[g+1];
        end

        dws_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl[g]),
            .i_load_value (i_value),
            .i_from_left  (w_left),
            .i_from_right (w_right),
            .i_tok        (w_tok_in),
            .i_key        (r_key),
            .o_data       (w_data[g]),
            .o_tok        (w_tok[g]),
            .o_hit        (w_hit[g])
        );
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_popped = r_out_popped;
        n_out_pos    = r_out_pos;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_popped = '0;
                    n_out_pos    = '0;
                    case (w_op)
                        OP_PUSH_FRONT, OP_PUSH_REAR: begin
                            if (w_full) n_out_status = ST_FULL;
                            else        n_count = r_count + CNT_W'(1);
                        end
                        OP_POP_FRONT: begin
                            if (w_empty) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_out_popped = w_data[0];
                                n_count      = r_count - CNT_W'(1);
                            end
                        end
                        OP_POP_REAR: begin
                            if (w_empty) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_out_popped = w_data[w_rear_idx];
                                n_count      = r_count - CNT_W'(1);
                            end
                        end
                        OP_SEARCH: begin
                            if (w_empty) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_out_valid = 1'b0;
                                n_idx       = '0;
                                n_state     = S_SEARCH;
                            end
                        end
                        default: n_out_status = ST_OK;
                    endcase
                end
            end
            S_SEARCH: begin
                if (w_any_hit) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_popped = '0;
                    n_out_pos    = w_pos_x[POS_W-1:0];
                    n_state      = S_IDLE;
                end else if (w_last) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_NOTFOUND;
                    n_out_popped = '0;
                    n_out_pos    = '0;
                    n_state      = S_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_out_status <= n_out_status;
        r_out_popped <= n_out_popped;
        r_out_pos    <= n_out_pos;
        if (w_start) begin
            r_key <= i_value;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_popped_value = r_out_popped;
    assign o_position     = r_out_pos;

endmodule

// ----- sv/dws_checker.sv -----
// ----------------------------------------------------------------------------
// dws_checker
// Port-level checks for the double-ended queue with search.
// ----------------------------------------------------------------------------
module dws_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_ready,
    input  logic                                o_valid,
    input  logic                                i_ready,
    input  logic [dws_pkg::STAT_W-1:0]          o_status,
    input  logic signed [dws_pkg::DATA_W-1:0]   o_popped_value,
    input  logic [dws_pkg::POS_W-1:0]           o_position
);
    import dws_pkg::*;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status)
            && $stable(o_popped_value) && $stable(o_position))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY || o_status == ST_FULL
            || o_status == ST_NOTFOUND) |-> o_popped_value == '0 && o_position == '0)
        else $error("failed operation carries data");

    a_pos_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_position != '0 |-> o_status == ST_OK && o_popped_value == '0)
        else $error("search hit with popped data");

    a_ready_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid || i_ready)
        else $error("input taken while result is stalled");

endmodule

bind deque_with_search dws_checker u_dws_checker (.*);

// ----- verif/deque_with_search_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_search_test
// Self-checking bench for the double-ended queue with linear search. A short
// table walks the empty, full, extreme-value and unused-code cases. Random
// fill, drain, mixed and search-heavy phases follow. Every result is checked
// against a local model of the deque, or against the table for pinned rows.
// ----------------------------------------------------------------------------
module deque_with_search_test;
    import dws_pkg::*;

    localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

    localparam logic signed [DATA_W-1:0] MAX_VAL  = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] MIN_VAL  = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] ALL_ONES = -32'sd1;
    localparam logic signed [DATA_W-1:0] FILL_BASE = 32'sh1000_0000;

    localparam int RANDOM_ITEMS = 510;
    localparam int PLAN_LEN     = 24;

    typedef struct {
        t_status                  status;
        logic signed [DATA_W-1:0] popped;
        logic [POS_W-1:0]         position;
    } t_result;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
        int                       reps;
        bit                       pinned;
        t_result                  want;
    } t_plan_row;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIX, PH_SEEK} t_phase;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic [OP_W-1:0]           i_operation;
    logic signed [DATA_W-1:0]  i_value;
    logic                      o_valid;
    logic                      i_ready;
    logic [STAT_W-1:0]         o_status;
    logic signed [DATA_W-1:0]  o_popped_value;
    logic [POS_W-1:0]          o_position;

    // model state
    logic signed [DATA_W-1:0]  dq_mem [DEPTH];
    logic [IDX_W-1:0]          dq_head  = '0;
    logic [CNT_W-1:0]          dq_count = '0;

    t_result                   expected_q [$];
    int                        err_count = 0;
    bit                        steady    = 1'b0;
    bit                        pin_on    = 1'b0;
    t_result                   pin_want;

    t_plan_row plan [PLAN_LEN] = '{
        '{OP_POP_FRONT,  32'sd0,  1, 1'b1, '{ST_EMPTY, 32'sd0, 5'd0}},
        '{OP_POP_REAR,   32'sd0,  1, 1'b1, '{ST_EMPTY, 32'sd0, 5'd0}},
        '{OP_SEARCH,     32'sd0,  1, 1'b1, '{ST_EMPTY, 32'sd0, 5'd0}},
        '{OP_RSVD_5,     MAX_VAL, 1, 1'b1, '{ST_OK, 32'sd0, 5'd0}},
        '{OP_PUSH_REAR,  MAX_VAL, 1, 1'b1, '{ST_OK, 32'sd0, 5'd0}},
        '{OP_PUSH_FRONT, MIN_VAL, 1, 1'b1, '{ST_OK, 32'sd0, 5'd0}},
        '{OP_SEARCH,     MAX_VAL, 1, 1'b0, '{ST_OK, 32'sd0, 5'd0}},
        '{OP_SEARCH,     MIN_VAL, 1, 1'b0, '{ST_OK, 32'sd0, 5'd0}},
        '{OP_SEARCH,     32'sd0,  1, 1'b1, '{ST_NOTFOUND, 32'sd0, 5'd0}},
        '{OP_POP_FRONT,  32'sd0,  1, 1'b1, '{ST_OK, MIN_VAL, 5'd0}},
        '{OP_POP_REAR,   32'sd0,  1, 1'b1, '{ST_OK, MAX_VAL, 5'd0}},
        '{OP_POP_REAR,   32'sd0,  1, 1'b1, '{ST_EMPTY, 32'sd0, 5'd0}},
        '{OP_PUSH_REAR,  FILL_BASE, DEPTH, 1'b0, '{ST_OK, 32'sd0, 5'd0}},
        '{OP_PUSH_REAR,  ALL_ONES, 1, 1'b1, '{ST_FULL, 32'sd0, 5'd0}},
        '{OP_PUSH_FRONT, 32'sd0,  1, 1'b1, '{ST_FULL, 32'sd0, 5'd0}},
        '{OP_SEARCH,     FILL_BASE + DEPTH - 1, 1, 1'b0, '{ST_OK, 32'sd0, 5'd0}},
        '{OP_SEARCH,     FILL_BASE, 1, 1'b0, '{ST_OK, 32'sd0, 5'd0}},
        '{OP_SEARCH,     ALL_ONES, 1, 1'b1, '{ST_NOTFOUND, 32'sd0, 5'd0}},
        '{OP_POP_FRONT,  32'sd0,  1, 1'b0, '{ST_OK, 32'sd0, 5'd0}},
        '{OP_PUSH_FRONT, FILL_BASE + 5, 1, 1'b0, '{ST_OK, 32'sd0, 5'd0}},
        '{OP_SEARCH,     FILL_BASE + 5, 1, 1'b0, '{ST_OK, 32'sd0, 5'd0}},
        '{OP_POP_REAR,   32'sd0,  1, 1'b0, '{ST_OK, 32'sd0, 5'd0}},
        '{OP_RSVD_7,     MIN_VAL, 1, 1'b1, '{ST_OK, 32'sd0, 5'd0}},
        '{OP_RSVD_6,     ALL_ONES, 1, 1'b1, '{ST_OK, 32'sd0, 5'd0}}
    };

    deque_with_search i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_position     (o_position)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_result deque_apply(input logic [OP_W-1:0] op,
                                            input logic signed [DATA_W-1:0] val);
        t_result r;
        r = '{ST_OK, '0, '0};
        case (op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
                if (dq_count == DEPTH) begin
                    r.status = ST_FULL;
                end else if (op == OP_PUSH_FRONT) begin
                    dq_head = IDX_W'((dq_head + DEPTH - 1) % DEPTH);
                    dq_mem[dq_head] = val;
                    dq_count++;
                end else begin
                    dq_mem[(dq_head + dq_count) % DEPTH] = val;
                    dq_count++;
                end
            end
            OP_POP_FRONT: begin
                if (dq_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.popped = dq_mem[dq_head];
                    dq_head  = IDX_W'((dq_head + 1) % DEPTH);
                    dq_count--;
                end
            end
            OP_POP_REAR: begin
                if (dq_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.popped = dq_mem[(dq_head + dq_count - 1) % DEPTH];
                    dq_count--;
                end
            end
            OP_SEARCH: begin
                if (dq_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.status = ST_NOTFOUND;
                    for (int i = 0; i < dq_count; i++) begin
                        if (dq_mem[(dq_head + i) % DEPTH] == val) begin
                            r.status   = ST_OK;
                            r.position = POS_W'(i + 1);
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic note_mismatch(input string what, input t_result want);
        if (err_count < 10) begin
            $display("%0t: %s: expected status %0d popped %0d pos %0d, got status %0d popped %0d pos %0d",
                     $realtime, what, want.status, want.popped, want.position,
                     o_status, o_popped_value, o_position);
        end
        err_count++;
    endtask

    // transaction monitor and scoreboard
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                want = deque_apply(i_operation, i_value);
                if (pin_on) want = pin_want;
                expected_q.push_back(want);
            end
            if (o_valid && i_ready) begin
                if (expected_q.size() == 0) begin
                    want = '{ST_OK, '0, '0};
                    note_mismatch("unexpected result", want);
                end else begin
                    want = expected_q.pop_front();
                    if (o_status !== want.status || o_popped_value !== want.popped ||
                        o_position !== want.position) begin
                        note_mismatch("result mismatch", want);
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_ready <= steady || ($urandom_range(99) >= 12);
    end

    task automatic send_op(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val,
                           input bit pinned, input t_result want);
        while (!steady && $urandom_range(99) < 12) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        pin_on      = pinned;
        pin_want    = want;
        i_valid     <= 1'b1;
        i_operation <= op;
        i_value     <= val;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        @(negedge i_clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_word();
        logic signed [DATA_W-1:0] w;
        int roll;
        roll = $urandom_range(99);
        if (roll < 30) begin
            w = $urandom_range(6);
            w = w - 3;
        end else if (roll < 40) begin
            case ($urandom_range(3))
                0: w = MAX_VAL;
                1: w = MIN_VAL;
                2: w = '0;
                default: w = ALL_ONES;
            endcase
        end else begin
            w = $urandom;
        end
        return w;
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input t_phase ph);
        int roll;
        roll = $urandom_range(99);
        if (roll < 3) return OP_W'($urandom_range(OP_RSVD_5, OP_RSVD_7));
        roll = $urandom_range(99);
        case (ph)
            PH_FILL:  if (roll < 75) return $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
                      else if (roll < 90) return OP_SEARCH;
            PH_DRAIN: if (roll < 75) return $urandom_range(1) ? OP_POP_REAR : OP_POP_FRONT;
                      else if (roll < 85) return OP_SEARCH;
            PH_SEEK:  if (roll < 60) return OP_SEARCH;
            default:  ;
        endcase
        case ($urandom_range(4))
            0: return OP_PUSH_FRONT;
            1: return OP_PUSH_REAR;
            2: return OP_POP_FRONT;
            3: return OP_POP_REAR;
            default: return OP_SEARCH;
        endcase
    endfunction

    initial begin
        t_result                  none;
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] val;
        t_phase                   ph;
        int                       sent;
        int                       run;
        none        = '{ST_OK, '0, '0};
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_operation = OP_PUSH_FRONT;
        i_value     = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[k]) begin
            for (int r = 0; r < plan[k].reps; r++) begin
                send_op(plan[k].op, plan[k].value + r, plan[k].pinned, plan[k].want);
            end
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            ph  = t_phase'($urandom_range(3));
            run = $urandom_range(8, 40);
            for (int j = 0; j < run && sent < RANDOM_ITEMS; j++) begin
                steady = (sent >= 200 && sent < 330);
                op     = pick_op(ph);
                val    = pick_word();
                if (op == OP_SEARCH && dq_count != 0 && $urandom_range(99) < 60) begin
                    val = dq_mem[(dq_head + $urandom_range(dq_count - 1)) % DEPTH];
                end
                send_op(op, val, 1'b0, none);
                sent++;
            end
        end
        steady = 1'b0;
        i_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 4) @(posedge i_clk);
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
